/* sv/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tsq_pkg.sv */
// ----------------------------------------------------------------------------
// tsq_pkg
// Types, constants and helpers of the timestamp event queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int CAPACITY    = 64;
    localparam int TYPE_COUNT  = 8;
    localparam int TIME_BITS   = 48;
    localparam int TYPE_BITS   = 3;
    localparam int HANDLE_BITS = 32;
    localparam int CNT_BITS    = 32;
    localparam int RETRY_BITS  = 10;
    localparam int IDX_BITS    = $clog2(CAPACITY);
    localparam int FILL_BITS   = $clog2(CAPACITY + 1);
    localparam int SLOT_BITS   = TIME_BITS + TYPE_BITS + HANDLE_BITS;
    localparam int PADDR_BITS  = 2;

    localparam logic [RETRY_BITS-1:0] MAX_RETRIES_RESET = RETRY_BITS'(1000);
    localparam logic [PADDR_BITS-1:0] ADDR_MAX_RETRIES  = '0;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_ADD_EXP = 3'd2;
    localparam logic [2:0] OP_ADD_ACT = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic [2:0]             op;
        logic [TIME_BITS-1:0]   event_time;
        logic [TYPE_BITS-1:0]   event_type;
        logic [HANDLE_BITS-1:0] event_payload;
        logic [CNT_BITS-1:0]    amount;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [TIME_BITS-1:0]   out_time;
        logic [TYPE_BITS-1:0]   out_type;
        logic [HANDLE_BITS-1:0] out_payload;
        logic [CNT_BITS-1:0]    type_current;
        logic [CNT_BITS-1:0]    type_expected;
        logic [CNT_BITS-1:0]    type_actual;
        logic [CNT_BITS-1:0]    all_current;
        logic [CNT_BITS-1:0]    all_expected;
        logic [CNT_BITS-1:0]    all_actual;
        logic [FILL_BITS-1:0]   queue_fill;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_INS_RD, S_INS_CMP, S_INS_WR,
        S_POP_RD, S_POP_CMP, S_POP_LAST_RD, S_POP_WR, S_FINISH
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec_misc;
        logic set_full;
        logic set_empty;
        logic set_exhausted;
        logic ins_init;
        logic ins_bump;
        logic scan_next;
        logic pop_init;
        logic pop_cmp;
        logic last_rd;
        logic ins_wr;
        logic pop_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       fill_zero;
        logic       fill_full;
        logic       hit;
        logic       k_max;
        logic       scan_last;
        logic       out_busy;
    } t_stat;

    function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                    input logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
    endfunction

endpackage

/* sv/tsq_if.sv */
// ----------------------------------------------------------------------------
// tsq_req_if / tsq_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface tsq_req_if import tsq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsq_rsp_if import tsq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/tsq_ram.sv */
// ----------------------------------------------------------------------------
// tsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/tsq_ctrl.sv */
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencer: dispatches a request and steps the store scans.
// ----------------------------------------------------------------------------
module tsq_ctrl import tsq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.fill_full)      n_state = S_FINISH;
                        else if (i_stat.fill_zero) n_state = S_INS_WR;
                        else                       n_state = S_INS_RD;
                    end
                    OP_POP: begin
                        n_state = i_stat.fill_zero ? S_FINISH : S_POP_RD;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_INS_RD: n_state = S_INS_CMP;
            S_INS_CMP: begin
                if (i_stat.hit) begin
                    n_state = i_stat.k_max ? S_FINISH : S_INS_RD;
                end else begin
                    n_state = i_stat.scan_last ? S_INS_WR : S_INS_RD;
                end
            end
            S_INS_WR: n_state = S_FINISH;
            S_POP_RD: n_state = S_POP_CMP;
            S_POP_CMP: n_state = i_stat.scan_last ? S_POP_LAST_RD : S_POP_RD;
            S_POP_LAST_RD: n_state = S_POP_WR;
            S_POP_WR: n_state = S_FINISH;
            S_FINISH: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.latch = i_req_valid;
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        o_cmd.set_full = i_stat.fill_full;
                        o_cmd.ins_init = !i_stat.fill_full;
                    end
                    OP_POP: begin
                        o_cmd.set_empty = i_stat.fill_zero;
                        o_cmd.pop_init  = !i_stat.fill_zero;
                    end
                    default: o_cmd.exec_misc = 1'b1;
                endcase
            end
            S_INS_CMP: begin
                o_cmd.set_exhausted = i_stat.hit && i_stat.k_max;
                o_cmd.ins_bump      = i_stat.hit && !i_stat.k_max;
                o_cmd.scan_next     = !i_stat.hit && !i_stat.scan_last;
            end
            S_INS_WR: o_cmd.ins_wr = 1'b1;
            S_POP_CMP: begin
                o_cmd.pop_cmp   = 1'b1;
                o_cmd.scan_next = !i_stat.scan_last;
            end
            S_POP_LAST_RD: o_cmd.last_rd = 1'b1;
            S_POP_WR: o_cmd.pop_wr = 1'b1;
            S_FINISH: o_cmd.load_out = !i_stat.out_busy;
            default: ;
        endcase
    end
endmodule

/* sv/tsq_dp.sv */
// ----------------------------------------------------------------------------
// tsq_dp
// Datapath: event store, retry search, minimum scan, counters, result reg.
// ----------------------------------------------------------------------------
module tsq_dp import tsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [RETRY_BITS-1:0] i_max_retries,
    input  t_req                  i_req_data,
    output logic                  o_rsp_valid,
    output t_rsp                  o_rsp_data,
    input  logic                  i_rsp_ready
);
    t_req                   r_in;
    logic [FILL_BITS-1:0]   r_fill;
    logic [IDX_BITS-1:0]    r_idx;
    logic [TIME_BITS-1:0]   r_cand;
    logic [RETRY_BITS-1:0]  r_k;
    logic [IDX_BITS-1:0]    r_best_idx;
    logic [SLOT_BITS-1:0]   r_best;
    logic [1:0]             r_res_status;
    logic [TIME_BITS-1:0]   r_res_time;
    logic [TYPE_BITS-1:0]   r_res_type;
    logic [HANDLE_BITS-1:0] r_res_pay;
    logic [CNT_BITS-1:0]    r_res_tcur, r_res_texp, r_res_tact;
    logic                   r_known [TYPE_COUNT];
    logic [CNT_BITS-1:0]    r_tcur [TYPE_COUNT];
    logic [CNT_BITS-1:0]    r_texp [TYPE_COUNT];
    logic [CNT_BITS-1:0]    r_tact [TYPE_COUNT];
    logic [CNT_BITS-1:0]    r_all_cur, r_all_exp, r_all_act;
    logic                   r_out_valid;
    t_rsp                   r_out;

    logic                   ram_we;
    logic [IDX_BITS-1:0]    ram_waddr, ram_raddr;
    logic [SLOT_BITS-1:0]   ram_wdata, ram_rdata;
    logic [TIME_BITS-1:0]   rd_time;
    logic [FILL_BITS-1:0]   fill_m1;
    logic [TYPE_BITS-1:0]   pop_ty;
    logic [CNT_BITS-1:0]    pop_cur;
    logic                   ty_ok;

    tsq_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign fill_m1   = r_fill - FILL_BITS'(1);
    assign rd_time   = ram_rdata[SLOT_BITS-1 -: TIME_BITS];
    assign ram_raddr = i_cmd.last_rd ? fill_m1[IDX_BITS-1:0] : r_idx;
    assign ram_we    = i_cmd.ins_wr || i_cmd.pop_wr;
    assign ram_waddr = i_cmd.ins_wr ? r_fill[IDX_BITS-1:0] : r_best_idx;
    assign ram_wdata = i_cmd.ins_wr ? {r_cand, r_in.event_type, r_in.event_payload}
                                    : ram_rdata;
    assign pop_ty    = r_best[HANDLE_BITS +: TYPE_BITS];
    assign pop_cur   = sat_add(r_tcur[pop_ty], CNT_BITS'(1));
    assign ty_ok     = int'(r_in.event_type) < TYPE_COUNT;

    assign o_stat.op        = r_in.op;
    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.fill_full = (int'(r_fill) >= CAPACITY);
    assign o_stat.hit       = (rd_time == r_cand);
    assign o_stat.k_max     = (r_k == i_max_retries);
    assign o_stat.scan_last = ({1'b0, r_idx} == fill_m1);
    assign o_stat.out_busy  = r_out_valid && !i_rsp_ready;

    // scan, search and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in         <= i_req_data;
            r_res_status <= ST_OK;
            r_res_time   <= '0;
            r_res_type   <= '0;
            r_res_pay    <= '0;
            r_res_tcur   <= '0;
            r_res_texp   <= '0;
            r_res_tact   <= '0;
        end
        if (i_cmd.set_full)      r_res_status <= ST_FULL;
        if (i_cmd.set_empty)     r_res_status <= ST_EMPTY;
        if (i_cmd.set_exhausted) r_res_status <= ST_EXHAUSTED;
        if (i_cmd.ins_init) begin
            r_cand <= r_in.event_time;
            r_k    <= '0;
            r_idx  <= '0;
        end
        if (i_cmd.pop_init) r_idx <= '0;
        if (i_cmd.ins_bump) begin
            r_cand <= r_cand + TIME_BITS'(1);
            r_k    <= r_k + RETRY_BITS'(1);
            r_idx  <= '0;
        end
        if (i_cmd.scan_next) r_idx <= r_idx + IDX_BITS'(1);
        if (i_cmd.pop_cmp) begin
            if (r_idx == '0 || rd_time < r_best[SLOT_BITS-1 -: TIME_BITS]) begin
                r_best     <= ram_rdata;
                r_best_idx <= r_idx;
            end
        end
        if (i_cmd.ins_wr) r_res_time <= r_cand;
        if (i_cmd.pop_wr) begin
            r_res_time <= r_best[SLOT_BITS-1 -: TIME_BITS];
            r_res_type <= pop_ty;
            r_res_pay  <= r_best[HANDLE_BITS-1:0];
            if (r_known[pop_ty]) begin
                r_res_tcur <= pop_cur;
                r_res_texp <= r_texp[pop_ty];
                r_res_tact <= r_tact[pop_ty];
            end else begin
                r_res_tcur <= CNT_BITS'(1);
            end
        end
    end

    // fill level and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_all_cur <= '0;
            r_all_exp <= '0;
            r_all_act <= '0;
            for (int i = 0; i < TYPE_COUNT; i++) begin
                r_known[i] <= 1'b0;
                r_tcur[i]  <= '0;
                r_texp[i]  <= '0;
                r_tact[i]  <= '0;
            end
        end else begin
            if (i_cmd.ins_wr) r_fill <= r_fill + FILL_BITS'(1);
            if (i_cmd.pop_wr) begin
                r_fill    <= fill_m1;
                r_all_cur <= sat_add(r_all_cur, CNT_BITS'(1));
                if (r_known[pop_ty]) r_tcur[pop_ty] <= pop_cur;
            end
            if (i_cmd.exec_misc) begin
                case (r_in.op)
                    OP_ADD_EXP: begin
                        if (ty_ok) begin
                            r_known[r_in.event_type] <= 1'b1;
                            r_tcur[r_in.event_type]  <= '0;
                            if (r_known[r_in.event_type]) begin
                                r_texp[r_in.event_type] <=
                                    sat_add(r_texp[r_in.event_type], r_in.amount);
                                r_tact[r_in.event_type] <=
                                    sat_add(r_tact[r_in.event_type], r_in.amount);
                            end else begin
                                r_texp[r_in.event_type] <= r_in.amount;
                                r_tact[r_in.event_type] <= r_in.amount;
                            end
                        end
                        r_all_exp <= sat_add(r_all_exp, r_in.amount);
                        r_all_act <= sat_add(r_all_act, r_in.amount);
                    end
                    OP_ADD_ACT: begin
                        if (ty_ok && r_known[r_in.event_type]) begin
                            r_tact[r_in.event_type] <=
                                sat_add(r_tact[r_in.event_type], r_in.amount);
                        end
                    end
                    OP_CLEAR: begin
                        r_fill    <= '0;
                        r_all_cur <= '0;
                        for (int i = 0; i < TYPE_COUNT; i++) begin
                            r_tcur[i] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status        <= r_res_status;
            r_out.out_time      <= r_res_time;
            r_out.out_type      <= r_res_type;
            r_out.out_payload   <= r_res_pay;
            r_out.type_current  <= r_res_tcur;
            r_out.type_expected <= r_res_texp;
            r_out.type_actual   <= r_res_tact;
            r_out.all_current   <= r_all_cur;
            r_out.all_expected  <= r_all_exp;
            r_out.all_actual    <= r_all_act;
            r_out.queue_fill    <= r_fill;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;
endmodule

/* sv/timestamp_event_queue.sv */
// ----------------------------------------------------------------------------
// timestamp_event_queue
// Timestamp-keyed event queue with per-type progress counters.
// ----------------------------------------------------------------------------
// Requests enter on i_req (valid/ready), one result per request leaves on
// o_rsp (valid/ready). One request is processed at a time; the next request
// is taken once the current result sits in the output register, so a stalled
// receiver holds at most one result and one request in flight.
// Steps per request, fill = events held:
//   pop:     scan of all fill entries of the store RAM for the minimum (read, then compare)
//   insert:  scan of the store for a collision; each collision bumps the time and rescans
//   others:  dispatch and finish only
// The store RAM has one registered read port, which sets the scan rate.
// Entries are kept unordered; a pop fills its hole with the last entry.
// Reset (synchronous) empties the queue, clears all counters and type
// registrations, and sets max_retries to 1000. The APB port holds
// max_retries at address 0; write it only while the block is idle.
// ----------------------------------------------------------------------------
module timestamp_event_queue import tsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tsq_req_if.sink               i_req,
    tsq_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [RETRY_BITS-1:0] r_max_retries;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= MAX_RETRIES_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_MAX_RETRIES) begin
            r_max_retries <= pwdata[RETRY_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_RETRIES) ? {{(32-RETRY_BITS){1'b0}}, r_max_retries}
                                                : '0;

    tsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tsq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_max_retries (r_max_retries),
        .i_req_data    (i_req.data),
        .o_rsp_valid   (o_rsp.valid),
        .o_rsp_data    (o_rsp.data),
        .i_rsp_ready   (o_rsp.ready)
    );
endmodule

/* sv/tsq_checker.sv */
// ----------------------------------------------------------------------------
// tsq_checker
// Port-level checks on the event queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsq_checker import tsq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input t_rsp rsp_data
);
    `TSQ_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")
    `TSQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, req_valid && req_ready, !req_ready, "request taken while another is in work")
    `TSQ_ASSERT(a_fill_bound, i_clk, i_rst_n, !rsp_valid || int'(rsp_data.queue_fill) <= CAPACITY, "queue fill above capacity")
    `TSQ_ASSERT(a_empty_fields, i_clk, i_rst_n, !(rsp_valid && rsp_data.status == ST_EMPTY) || (rsp_data.queue_fill == '0 && rsp_data.out_time == '0), "empty status with data")
endmodule

bind timestamp_event_queue tsq_checker u_tsq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .rsp_valid (o_rsp.valid),
    .rsp_ready (o_rsp.ready),
    .rsp_data  (o_rsp.data)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timestamp event queue.
// ----------------------------------------------------------------------------
// Requests come from a queue that the sequence block fills. A clocked driver
// sends them with random gaps and a clocked monitor takes results with random
// stalls. Each accepted request is run through a model of the sorted store
// and counters here; every result is compared field by field. max_retries is
// changed between phases over the APB port, extremes included.
// ----------------------------------------------------------------------------
module tb;
    import tsq_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

    typedef struct {
        logic [TIME_BITS-1:0]   ts;
        logic [TYPE_BITS-1:0]   kind;
        logic [HANDLE_BITS-1:0] handle;
    } t_event;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tsq_req_if req_if ();
    tsq_rsp_if rsp_if ();

    timestamp_event_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    t_event                  store_q[$];
    logic [RETRY_BITS-1:0]   retry_limit;
    logic                    kind_known [TYPE_COUNT];
    logic [CNT_BITS-1:0]     kind_cur [TYPE_COUNT];
    logic [CNT_BITS-1:0]     kind_exp [TYPE_COUNT];
    logic [CNT_BITS-1:0]     kind_act [TYPE_COUNT];
    logic [CNT_BITS-1:0]     sum_cur;
    logic [CNT_BITS-1:0]     sum_exp;
    logic [CNT_BITS-1:0]     sum_act;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors;
    int   cyc;
    int   idle_cycles;
    logic [TIME_BITS-1:0] base_ts;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [CNT_BITS-1:0] add_clamped(logic [CNT_BITS-1:0] a,
                                                        logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? {CNT_BITS{1'b1}} : s[CNT_BITS-1:0];
    endfunction

    function automatic bit ts_taken(logic [TIME_BITS-1:0] t);
        foreach (store_q[i]) if (store_q[i].ts == t) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_rsp queue_step(t_req r);
        t_rsp   res;
        t_event ev;
        logic [TIME_BITS-1:0] cand;
        bit     found;
        int     pos;
        res = '0;
        case (r.op)
            OP_INSERT: begin
                if (store_q.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    cand = r.event_time;
                    found = 1'b0;
                    for (int k = 0; k <= int'(retry_limit); k++) begin
                        if (!ts_taken(cand)) begin
                            found = 1'b1;
                            break;
                        end
                        cand = cand + 1'b1;
                    end
                    if (!found) begin
                        res.status = ST_EXHAUSTED;
                    end else begin
                        pos = 0;
                        while (pos < store_q.size() && store_q[pos].ts < cand) pos++;
                        ev.ts = cand;
                        ev.kind = r.event_type;
                        ev.handle = r.event_payload;
                        store_q.insert(pos, ev);
                        res.out_time = cand;
                    end
                end
            end
            OP_POP: begin
                if (store_q.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    ev = store_q.pop_front();
                    res.out_time = ev.ts;
                    res.out_type = ev.kind;
                    res.out_payload = ev.handle;
                    sum_cur = add_clamped(sum_cur, 1);
                    if (kind_known[ev.kind]) begin
                        kind_cur[ev.kind] = add_clamped(kind_cur[ev.kind], 1);
                        res.type_current = kind_cur[ev.kind];
                        res.type_expected = kind_exp[ev.kind];
                        res.type_actual = kind_act[ev.kind];
                    end else begin
                        res.type_current = 1;
                    end
                end
            end
            OP_ADD_EXP: begin
                if (!kind_known[r.event_type]) begin
                    kind_known[r.event_type] = 1'b1;
                    kind_exp[r.event_type] = r.amount;
                    kind_act[r.event_type] = r.amount;
                end else begin
                    kind_exp[r.event_type] = add_clamped(kind_exp[r.event_type], r.amount);
                    kind_act[r.event_type] = add_clamped(kind_act[r.event_type], r.amount);
                end
                kind_cur[r.event_type] = '0;
                sum_exp = add_clamped(sum_exp, r.amount);
                sum_act = add_clamped(sum_act, r.amount);
            end
            OP_ADD_ACT: begin
                if (kind_known[r.event_type])
                    kind_act[r.event_type] = add_clamped(kind_act[r.event_type], r.amount);
            end
            OP_CLEAR: begin
                store_q.delete();
                sum_cur = '0;
                foreach (kind_cur[i]) kind_cur[i] = '0;
            end
            default: ;
        endcase
        res.all_current = sum_cur;
        res.all_expected = sum_exp;
        res.all_actual = sum_act;
        res.queue_fill = FILL_BITS'(store_q.size());
        return res;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task automatic compare_rsp(t_rsp got, t_rsp want);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.out_time !== want.out_time) report("out_time", got.out_time, want.out_time);
        if (got.out_type !== want.out_type) report("out_type", got.out_type, want.out_type);
        if (got.out_payload !== want.out_payload)
            report("out_payload", got.out_payload, want.out_payload);
        if (got.type_current !== want.type_current)
            report("type_current", got.type_current, want.type_current);
        if (got.type_expected !== want.type_expected)
            report("type_expected", got.type_expected, want.type_expected);
        if (got.type_actual !== want.type_actual)
            report("type_actual", got.type_actual, want.type_actual);
        if (got.all_current !== want.all_current)
            report("all_current", got.all_current, want.all_current);
        if (got.all_expected !== want.all_expected)
            report("all_expected", got.all_expected, want.all_expected);
        if (got.all_actual !== want.all_actual)
            report("all_actual", got.all_actual, want.all_actual);
        if (got.queue_fill !== want.queue_fill)
            report("queue_fill", got.queue_fill, want.queue_fill);
    endtask

    function automatic bit quiet_stretch();
        return cyc >= 30000 && cyc < 45000;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                expected_rsps.push_back(queue_step(req_if.data));
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() > 0 &&
                    (quiet_stretch() || $urandom_range(0, 99) >= 13)) begin
                    req_if.valid <= 1'b1;
                    req_if.data <= pending_reqs.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("[%0t] result with no request outstanding", $realtime);
                end else begin
                    compare_rsp(rsp_if.data, expected_rsps.pop_front());
                end
            end
            rsp_if.ready <= quiet_stretch() || $urandom_range(0, 99) >= 13;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timestamp_event_queue regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(logic [2:0] op, logic [TIME_BITS-1:0] ts, logic [2:0] kind,
                            logic [31:0] handle, logic [31:0] amount);
        t_req r;
        r.op = op;
        r.event_time = ts;
        r.event_type = kind;
        r.event_payload = handle;
        r.amount = amount;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_if.valid)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_retries(logic [RETRY_BITS-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_RETRIES;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        retry_limit = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[RETRY_BITS-1:0] !== v) report("max_retries readback", prdata, v);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [TIME_BITS-1:0] pick_ts();
        int m;
        m = $urandom_range(0, 99);
        if (m < 50) return base_ts + TIME_BITS'($urandom_range(0, 40));
        if (m < 70) return {16'($urandom), 32'($urandom)};
        if (m < 85) return TIME_TOP - TIME_BITS'($urandom_range(0, 8));
        return TIME_BITS'($urandom_range(0, 8));
    endfunction

    function automatic logic [31:0] pick_amount();
        int m;
        m = $urandom_range(0, 99);
        if (m < 70) return $urandom_range(0, 20);
        if (m < 90) return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endfunction

    task automatic random_reqs(int n);
        int m;
        for (int i = 0; i < n; i++) begin
            m = $urandom_range(0, 99);
            if (m < 45)
                push_req(OP_INSERT, pick_ts(), 3'($urandom), $urandom, $urandom);
            else if (m < 75)
                push_req(OP_POP, {16'($urandom), 32'($urandom)}, 3'($urandom), $urandom,
                         $urandom);
            else if (m < 85)
                push_req(OP_ADD_EXP, pick_ts(), 3'($urandom), $urandom, pick_amount());
            else if (m < 95)
                push_req(OP_ADD_ACT, pick_ts(), 3'($urandom), $urandom, pick_amount());
            else if (m < 97)
                push_req(OP_CLEAR, pick_ts(), 3'($urandom), $urandom, $urandom);
            else
                push_req(3'($urandom_range(5, 7)), pick_ts(), 3'($urandom), $urandom,
                         $urandom);
        end
    endtask

    // fill to capacity, overflow, then partly empty
    task automatic fill_burst();
        for (int i = 0; i < CAPACITY + 2; i++)
            push_req(OP_INSERT, pick_ts(), 3'($urandom), $urandom, $urandom);
        for (int i = 0; i < 40; i++)
            push_req(OP_POP, '0, '0, '0, '0);
    endtask

    initial begin
        logic [RETRY_BITS-1:0] phase_retries [5];
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        errors = 0;
        cyc = 0;
        idle_cycles = 0;
        retry_limit = MAX_RETRIES_RESET;
        sum_cur = '0;
        sum_exp = '0;
        sum_act = '0;
        foreach (kind_known[i]) begin
            kind_known[i] = 1'b0;
            kind_cur[i] = '0;
            kind_exp[i] = '0;
            kind_act[i] = '0;
        end
        base_ts = 48'h1000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset retry limit
        push_req(OP_POP, '0, '0, '0, '0);                          // empty pop
        push_req(OP_ADD_ACT, '0, 3'd2, '0, 32'd9);                 // unregistered type
        push_req(OP_INSERT, TIME_TOP, 3'd7, 32'hFFFF_FFFF, '0);
        push_req(OP_INSERT, TIME_TOP, 3'd2, 32'h1, '0);            // wraps to zero
        push_req(OP_INSERT, '0, 3'd2, 32'h2, '0);                  // bumps to one
        push_req(OP_ADD_EXP, '0, 3'd2, '0, 32'hFFFF_FFF0);
        push_req(OP_ADD_EXP, '0, 3'd2, '0, 32'h20);                // saturation
        push_req(OP_ADD_ACT, '0, 3'd2, '0, 32'h5);
        push_req(OP_POP, '0, '0, '0, '0);                          // registered type
        push_req(OP_POP, '0, '0, '0, '0);
        push_req(OP_POP, '0, '0, '0, '0);                          // unregistered type
        push_req(3'd5, TIME_TOP, 3'd7, '1, '1);
        push_req(3'd6, '0, '0, '0, '0);
        push_req(3'd7, '0, '0, '0, '0);
        push_req(OP_INSERT, 48'h5555_5555_5555, 3'd2, 32'hAAAA_AAAA, '0);
        push_req(OP_CLEAR, '0, '0, '0, '0);
        push_req(OP_POP, '0, '0, '0, '0);
        push_req(OP_ADD_EXP, '0, 3'd2, '0, 32'd3);                 // clears current
        drain();

        // zero retries: any collision is exhausted
        set_retries('0);
        push_req(OP_INSERT, 48'd100, 3'd1, 32'd1, '0);
        push_req(OP_INSERT, 48'd100, 3'd1, 32'd2, '0);
        push_req(OP_POP, '0, '0, '0, '0);
        drain();

        phase_retries[0] = 10'd1023;
        phase_retries[1] = 10'd3;
        phase_retries[2] = MAX_RETRIES_RESET;
        phase_retries[3] = 10'd0;
        phase_retries[4] = 10'($urandom_range(1, 1022));
        foreach (phase_retries[p]) begin
            set_retries(phase_retries[p]);
            base_ts = {16'($urandom), 32'($urandom)};
            random_reqs(100);
            fill_burst();
            random_reqs(80);
            drain();
        end

        if (errors == 0) begin
            $display("timestamp_event_queue regression: pass");
        end else begin
            $display("timestamp_event_queue regression: fail");
        end
        $finish;
    end
endmodule
